/* rtl/npcq_pkg.sv */
package npcq_pkg;

    // Palette geometry.
    localparam int PALETTE_ENTRIES = 256;
    localparam int IDX_W           = $clog2(PALETTE_ENTRIES);

    // Component and distance widths.
    localparam int COMP_W = 8;
    localparam int SQ_W   = 2 * COMP_W;
    localparam int DIST_W = SQ_W + 2;

    // Pixels with alpha below this value are transparent.
    localparam logic [COMP_W-1:0] ALPHA_OPAQUE_MIN = 8'd128;

    // Search start value, larger than any real distance.
    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(255 * 255 * 3 + 1);

    // Divide by three as multiply by 683 and shift by 11; exact for sums below 2048.
    localparam int                GRAY_SUM_W = COMP_W + 2;
    localparam int                GRAY_SHIFT = 11;
    localparam logic [GRAY_SUM_W-1:0] GRAY_RECIP = GRAY_SUM_W'(683);

    // Input item kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    // Sequencer states, one-hot.
    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SEARCH = 3'b010,
        ST_DONE   = 3'b100
    } t_state;

    // Tag that travels with a palette entry through the distance unit.
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
    } t_dist_tag;

endpackage

/* rtl/npcq_dist.sv */
module npcq_dist (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  npcq_pkg::t_dist_tag             i_tag,
    input  logic [npcq_pkg::COMP_W-1:0]     i_pix_r,
    input  logic [npcq_pkg::COMP_W-1:0]     i_pix_g,
    input  logic [npcq_pkg::COMP_W-1:0]     i_pix_b,
    input  logic [3*npcq_pkg::COMP_W-1:0]   i_pal,
    output npcq_pkg::t_dist_tag             o_tag,
    output logic [npcq_pkg::DIST_W-1:0]     o_dist
);

    logic [npcq_pkg::COMP_W-1:0] w_pal_r, w_pal_g, w_pal_b;
    logic [npcq_pkg::COMP_W-1:0] w_dr, w_dg, w_db;
    logic [npcq_pkg::SQ_W-1:0]   r_sq_r, r_sq_g, r_sq_b;
    npcq_pkg::t_dist_tag         r_tag_s1, r_tag_s2;
    logic [npcq_pkg::DIST_W-1:0] r_dist;

    // Split the stored entry into its components.
    assign w_pal_r = i_pal[3*npcq_pkg::COMP_W-1:2*npcq_pkg::COMP_W];
    assign w_pal_g = i_pal[2*npcq_pkg::COMP_W-1:npcq_pkg::COMP_W];
    assign w_pal_b = i_pal[npcq_pkg::COMP_W-1:0];

    // Absolute component differences.
    assign w_dr = (i_pix_r > w_pal_r) ? (i_pix_r - w_pal_r) : (w_pal_r - i_pix_r);
    assign w_dg = (i_pix_g > w_pal_g) ? (i_pix_g - w_pal_g) : (w_pal_g - i_pix_g);
    assign w_db = (i_pix_b > w_pal_b) ? (i_pix_b - w_pal_b) : (w_pal_b - i_pix_b);

    // First stage registers the three squares.
    always_ff @(posedge i_clk) begin
        r_sq_r <= npcq_pkg::SQ_W'(w_dr) * npcq_pkg::SQ_W'(w_dr);
        r_sq_g <= npcq_pkg::SQ_W'(w_dg) * npcq_pkg::SQ_W'(w_dg);
        r_sq_b <= npcq_pkg::SQ_W'(w_db) * npcq_pkg::SQ_W'(w_db);
        r_dist <= npcq_pkg::DIST_W'(r_sq_r) + npcq_pkg::DIST_W'(r_sq_g)
                + npcq_pkg::DIST_W'(r_sq_b);
    end

    // The tag follows the data through both stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_s1 <= '0;
            r_tag_s2 <= '0;
        end else begin
            r_tag_s1 <= i_tag;
            r_tag_s2 <= r_tag_s1;
        end
    end

    assign o_tag  = r_tag_s2;
    assign o_dist = r_dist;

endmodule

/* rtl/nearest_palette_color_quantizer_top.sv */
// Nearest palette color quantizer. A load item (kind 0) writes one palette entry, each
// component shifted left by two; a load beyond the palette is dropped. A pixel item (kind 1)
// yields one color index. With use_palette at 1, an opaque pixel (alpha 128 or more) is
// compared with entries 1 to PALETTE_ENTRIES-1 and the closest one in squared RGB distance
// wins, the lowest index on a tie. Its search is paced by the single palette read port
// feeding one distance unit an entry per cycle, plus the read and the two distance stages;
// the distance of the last entry sets the result register. A transparent pixel gives index
// 0 and a pixel with use_palette at 0 gives (r+g+b)/3, written to the result register at
// the transfer. Every result then moves to the output register once that is free, and only
// then is the next item taken. The input is stalled while a pixel is in progress and while
// its finished result waits for a stalled output register. Every entry that a search can
// reach must be loaded before the first palette-mode pixel;
// there is no clearing pass.
module nearest_palette_color_quantizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration
    input  logic       i_cfg_we,
    input  logic       i_cfg_data,
    // Input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [7:0] i_entry_index,
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    input  logic [7:0] i_alpha,
    // Output channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_color_index
);

    localparam logic [npcq_pkg::IDX_W-1:0] FIRST_IDX = npcq_pkg::IDX_W'(1);
    localparam logic [npcq_pkg::IDX_W-1:0] LAST_IDX  =
        npcq_pkg::IDX_W'(npcq_pkg::PALETTE_ENTRIES - 1);

    npcq_pkg::t_state r_state;
    logic             r_use_palette;

    logic [3*npcq_pkg::COMP_W-1:0] r_mem [npcq_pkg::PALETTE_ENTRIES];
    logic [3*npcq_pkg::COMP_W-1:0] r_rd_data;
    npcq_pkg::t_dist_tag           r_rd_tag;

    logic [npcq_pkg::IDX_W-1:0]    r_addr;
    logic                          r_issue;
    logic [7:0]                    r_pix_r, r_pix_g, r_pix_b;
    logic [npcq_pkg::DIST_W-1:0]   r_best_dist;
    logic [npcq_pkg::IDX_W-1:0]    r_best_idx;
    logic [7:0]                    r_result;
    logic                          r_out_valid;
    logic [7:0]                    r_out_index;

    logic                              w_accept;
    logic                              w_load_ok;
    logic [npcq_pkg::GRAY_SUM_W-1:0]   w_sum;
    logic [2*npcq_pkg::GRAY_SUM_W-1:0] w_prod;
    logic [7:0]                        w_gray;
    npcq_pkg::t_dist_tag               w_dist_tag;
    logic [npcq_pkg::DIST_W-1:0]       w_dist;
    logic                              w_better;
    logic [npcq_pkg::IDX_W-1:0]        n_best_idx;
    logic                              w_out_free;

    assign o_in_stall = (r_state != npcq_pkg::ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_load_ok  = ({1'b0, i_entry_index} < 9'(npcq_pkg::PALETTE_ENTRIES));

    // Grayscale average through a reciprocal multiply.
    assign w_sum  = npcq_pkg::GRAY_SUM_W'(i_red) + npcq_pkg::GRAY_SUM_W'(i_green)
                  + npcq_pkg::GRAY_SUM_W'(i_blue);
    assign w_prod = (2*npcq_pkg::GRAY_SUM_W)'(w_sum)
                  * (2*npcq_pkg::GRAY_SUM_W)'(npcq_pkg::GRAY_RECIP);
    assign w_gray = 8'(w_prod >> npcq_pkg::GRAY_SHIFT);

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_palette <= 1'b0;
        end else if (i_cfg_we) begin
            r_use_palette <= i_cfg_data;
        end
    end

    // Palette memory: written by load transfers, read one entry per search cycle.
    always_ff @(posedge i_clk) begin
        if (w_accept && (i_kind == npcq_pkg::KIND_LOAD) && w_load_ok) begin
            r_mem[i_entry_index[npcq_pkg::IDX_W-1:0]] <=
                {i_red << 2, i_green << 2, i_blue << 2};
        end
        r_rd_data <= r_mem[r_addr];
    end

    // Read tag marks which memory outputs belong to the search.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_tag <= '0;
        end else begin
            r_rd_tag.valid <= r_issue;
            r_rd_tag.idx   <= r_addr;
        end
    end

    npcq_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (r_rd_tag),
        .i_pix_r (r_pix_r),
        .i_pix_g (r_pix_g),
        .i_pix_b (r_pix_b),
        .i_pal   (r_rd_data),
        .o_tag   (w_dist_tag),
        .o_dist  (w_dist)
    );

    // Compare against the best so far; strict less keeps the lowest index on a tie.
    assign w_better   = w_dist_tag.valid && (w_dist < r_best_dist);
    assign n_best_idx = w_better ? w_dist_tag.idx : r_best_idx;

    // Pixel capture and running minimum.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix_r     <= i_red;
            r_pix_g     <= i_green;
            r_pix_b     <= i_blue;
            r_best_dist <= npcq_pkg::DIST_START;
            r_best_idx  <= FIRST_IDX;
            if (!r_use_palette) begin
                r_result <= w_gray;
            end else begin
                r_result <= 8'd0;
            end
        end else if (w_better) begin
            r_best_dist <= w_dist;
            r_best_idx  <= w_dist_tag.idx;
        end
        if (w_dist_tag.valid && (w_dist_tag.idx == LAST_IDX)) begin
            r_result <= 8'(n_best_idx);
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npcq_pkg::ST_IDLE;
            r_addr  <= FIRST_IDX;
            r_issue <= 1'b0;
        end else begin
            unique case (r_state)
                npcq_pkg::ST_IDLE: begin
                    if (w_accept && (i_kind == npcq_pkg::KIND_PIXEL)) begin
                        if (r_use_palette && (i_alpha >= npcq_pkg::ALPHA_OPAQUE_MIN)) begin
                            r_state <= npcq_pkg::ST_SEARCH;
                            r_addr  <= FIRST_IDX;
                            r_issue <= 1'b1;
                        end else begin
                            r_state <= npcq_pkg::ST_DONE;
                        end
                    end
                end
                npcq_pkg::ST_SEARCH: begin
                    if (r_issue) begin
                        if (r_addr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + FIRST_IDX;
                        end
                    end
                    if (w_dist_tag.valid && (w_dist_tag.idx == LAST_IDX)) begin
                        r_state <= npcq_pkg::ST_DONE;
                    end
                end
                npcq_pkg::ST_DONE: begin
                    if (w_out_free) begin
                        r_state <= npcq_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= npcq_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Output register: loaded from the result when free, cleared by a transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == npcq_pkg::ST_DONE) && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == npcq_pkg::ST_DONE) && w_out_free) begin
            r_out_index <= r_result;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_color_index = r_out_index;

endmodule

/* rtl/npcq_checker.sv */
module npcq_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       i_kind,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_color_index
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its value.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_color_index))
        else $error("result changed while stalled");

    // Reset empties the output register.
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // A palette load leaves the block ready for the next item.
    a_load_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_kind == npcq_pkg::KIND_LOAD) |=> !o_in_stall)
        else $error("block busy after a load transfer");

    // A pixel keeps the block busy until its result is handed over.
    a_pixel_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_kind == npcq_pkg::KIND_PIXEL) |=> o_in_stall)
        else $error("block ready right after a pixel transfer");

endmodule

bind nearest_palette_color_quantizer_top npcq_checker u_npcq_checker (.*);

/* test/tb.sv */
module tb;

    localparam int CLK_PERIOD      = 4;
    localparam int RESET_CYCLES    = 11;
    localparam int TIMEOUT_CYCLES  = 1_500_000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int DRAIN_CYCLES    = 300;
    localparam int HOLD_CYCLES     = 700;
    localparam int PHASE_COUNT     = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int PRESSURE_ITEMS  = 40;
    localparam int LOAD_PCT        = 35;
    localparam int NO_LITERAL      = -1;
    localparam int GRAY_DIVISOR    = 3;
    localparam int FARTHEST        = 255 * 255 * 3 + 1;
    localparam logic [7:0] TRANSPARENT_INDEX = 8'd0;

    // Names taken over from the block's package.
    localparam int         PALETTE_ENTRIES  = npcq_pkg::PALETTE_ENTRIES;
    localparam logic [7:0] ALPHA_OPAQUE_MIN = npcq_pkg::ALPHA_OPAQUE_MIN;
    localparam logic       KIND_LOAD        = npcq_pkg::KIND_LOAD;
    localparam logic       KIND_PIXEL       = npcq_pkg::KIND_PIXEL;

    // Sender idle and receiver stall percentages, one pair per two random phases.
    localparam int SEND_IDLE [4] = '{0, 76, 0, 26};
    localparam int RECV_STALL [4] = '{0, 0, 76, 26};

    typedef struct packed {
        logic       kind;
        logic [7:0] entry_index;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix_item;

    typedef enum logic [1:0] {
        STEP_ITEM,
        STEP_FILL,
        STEP_MODE
    } t_step_op;

    // One row of the directed script. For STEP_MODE rows, lit carries the register value.
    typedef struct {
        t_step_op  op;
        t_pix_item item;
        int        lit;
    } t_script_row;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic       kind = KIND_LOAD;
    logic [7:0] entry_index = 8'd0;
    logic [7:0] red = 8'd0;
    logic [7:0] green = 8'd0;
    logic [7:0] blue = 8'd0;
    logic [7:0] alpha = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] color_index;

    // Shadow copy of the palette and the mode register.
    logic [7:0] shadow_red [PALETTE_ENTRIES];
    logic [7:0] shadow_green [PALETTE_ENTRIES];
    logic [7:0] shadow_blue [PALETTE_ENTRIES];
    logic       shadow_use_palette = 1'b0;

    logic [7:0]  expected_colors [$];
    t_script_row script [$];
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;

    nearest_palette_color_quantizer_top dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_kind        (kind),
        .i_entry_index (entry_index),
        .i_red         (red),
        .i_green       (green),
        .i_blue        (blue),
        .i_alpha       (alpha),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_color_index (color_index)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Expected color index for a pixel, from the shadow palette and mode.
    function automatic logic [7:0] predict_color_index(t_pix_item it);
        int best_dist;
        int best;
        int sq_dist;
        int d_r;
        int d_g;
        int d_b;
        if (!shadow_use_palette) begin
            return 8'((int'(it.red) + int'(it.green) + int'(it.blue)) / GRAY_DIVISOR);
        end
        if (it.alpha < ALPHA_OPAQUE_MIN) begin
            return TRANSPARENT_INDEX;
        end
        best_dist = FARTHEST;
        best = 1;
        // Entry 0 is reserved for transparency and never takes part in the search.
        for (int e = 1; e < PALETTE_ENTRIES; e++) begin
            d_r = int'(it.red) - int'(shadow_red[e]);
            d_g = int'(it.green) - int'(shadow_green[e]);
            d_b = int'(it.blue) - int'(shadow_blue[e]);
            sq_dist = d_r * d_r + d_g * d_g + d_b * d_b;
            if (sq_dist < best_dist) begin
                best_dist = sq_dist;
                best = e;
            end
        end
        return 8'(best);
    endfunction

    // A component moved by a few steps, kept inside the byte range.
    function automatic logic [7:0] jitter(logic [7:0] c);
        int v;
        v = int'(c) + int'($urandom_range(6)) - 3;
        if (v < 0) begin
            v = 0;
        end else if (v > 255) begin
            v = 255;
        end
        return 8'(v);
    endfunction

    // Random item; pixels often sit close to a palette color, and some loads duplicate
    // an existing entry so that the search meets exact ties.
    function automatic t_pix_item random_item(int load_pct);
        t_pix_item it;
        int src;
        it.kind = KIND_PIXEL;
        it.entry_index = 8'($urandom_range(255));
        it.red = 8'($urandom_range(255));
        it.green = 8'($urandom_range(255));
        it.blue = 8'($urandom_range(255));
        it.alpha = 8'($urandom_range(255));
        if ($urandom_range(99) < load_pct) begin
            it.kind = KIND_LOAD;
            if ($urandom_range(3) == 0) begin
                src = $urandom_range(PALETTE_ENTRIES - 1);
                it.red = shadow_red[src] >> 2;
                it.green = shadow_green[src] >> 2;
                it.blue = shadow_blue[src] >> 2;
            end
        end else if ($urandom_range(2) == 0) begin
            src = $urandom_range(PALETTE_ENTRIES - 1, 1);
            it.red = jitter(shadow_red[src]);
            it.green = jitter(shadow_green[src]);
            it.blue = jitter(shadow_blue[src]);
        end
        return it;
    endfunction

    function automatic void add_row(t_step_op op, logic k, logic [7:0] idx, logic [7:0] r,
                                    logic [7:0] g, logic [7:0] b, logic [7:0] a, int lit);
        t_script_row row;
        row.op = op;
        row.item = '{kind: k, entry_index: idx, red: r, green: g, blue: b, alpha: a};
        row.lit = lit;
        script.push_back(row);
    endfunction

    // Offer one item and wait for its transfer; then update the shadow state.
    // A literal of NO_LITERAL means the expected color comes from the predictor.
    task automatic send_item(t_pix_item it, int lit);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= it.kind;
        entry_index <= it.entry_index;
        red <= it.red;
        green <= it.green;
        blue <= it.blue;
        alpha <= it.alpha;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        if (it.kind == KIND_LOAD) begin
            shadow_red[it.entry_index] = it.red << 2;
            shadow_green[it.entry_index] = it.green << 2;
            shadow_blue[it.entry_index] = it.blue << 2;
        end else if (lit != NO_LITERAL) begin
            expected_colors.push_back(8'(lit));
        end else begin
            expected_colors.push_back(predict_color_index(it));
        end
    endtask

    task automatic wait_for_results();
        while (expected_colors.size() != 0) begin
            @(posedge clk);
        end
    endtask

    // Mode changes only while the block is idle: drain, let a load finish, then write.
    task automatic set_palette_mode(logic value);
        in_valid <= 1'b0;
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_use_palette = value;
    endtask

    // Output side: check each transfer and drive the stall, with an occasional long hold-off.
    always @(posedge clk) begin
        logic [7:0] want;
        if (rst_n && out_valid && !out_stall) begin
            if (expected_colors.size() == 0) begin
                $display("%0t: unexpected color_index %0d, expected none", $time, color_index);
                mismatch_count++;
            end else begin
                want = expected_colors.pop_front();
                if (color_index !== want) begin
                    $display("%0t: color_index mismatch: expected %0d, actual %0d",
                             $time, want, color_index);
                    mismatch_count++;
                end
            end
        end
        if (hold_requests != hold_served) begin
            hold_served <= hold_served + 1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Main sequence: directed script, random phases, back-pressure, then the verdict.
    initial begin
        t_pix_item it;
        // Start the shadow palette from known values, so that copied entries are never
        // unknown while the palette is being filled.
        foreach (shadow_red[e]) begin
            shadow_red[e] = 8'd0;
            shadow_green[e] = 8'd0;
            shadow_blue[e] = 8'd0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Grayscale mode after reset; alpha is ignored.
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 255);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd1, 8'd1, 8'd0, 8'd128, 0);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd2, 8'd2, 8'd1, 8'd128, 1);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd3, 8'd3, 8'd3, 8'd0, 3);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd255, 8'd255, 8'd254, 8'd127, 254);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd100, 8'd0, 8'd0, 8'd255, 33);
        // Whole palette, then a few known entries: a tie pair, a wrapping shift, black,
        // white, and entry 0 which the search never reaches.
        add_row(STEP_FILL, KIND_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, NO_LITERAL);
        add_row(STEP_ITEM, KIND_LOAD, 8'd5, 8'd10, 8'd20, 8'd30, 8'd255, NO_LITERAL);
        add_row(STEP_ITEM, KIND_LOAD, 8'd9, 8'd10, 8'd20, 8'd30, 8'd255, NO_LITERAL);
        add_row(STEP_ITEM, KIND_LOAD, 8'd7, 8'd255, 8'd64, 8'd65, 8'd0, NO_LITERAL);
        add_row(STEP_ITEM, KIND_LOAD, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, NO_LITERAL);
        add_row(STEP_ITEM, KIND_LOAD, 8'd255, 8'd63, 8'd63, 8'd63, 8'd0, NO_LITERAL);
        add_row(STEP_ITEM, KIND_LOAD, 8'd0, 8'd63, 8'd0, 8'd63, 8'd0, NO_LITERAL);
        // Palette mode: transparency threshold, exact match, ties and extremes.
        add_row(STEP_MODE, KIND_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd127, 0);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 8'd128, 1);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd40, 8'd80, 8'd120, 8'd255, NO_LITERAL);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd252, 8'd0, 8'd4, 8'd200, NO_LITERAL);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, NO_LITERAL);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd252, 8'd0, 8'd252, 8'd255, NO_LITERAL);
        add_row(STEP_MODE, KIND_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 0);
        add_row(STEP_ITEM, KIND_PIXEL, 8'd0, 8'd255, 8'd0, 8'd0, 8'd3, 85);

        foreach (script[n]) begin
            case (script[n].op)
                STEP_MODE: begin
                    set_palette_mode(script[n].lit[0]);
                end
                STEP_FILL: begin
                    for (int e = 0; e < PALETTE_ENTRIES; e++) begin
                        it = random_item(100);
                        it.entry_index = 8'(e);
                        send_item(it, NO_LITERAL);
                    end
                end
                default: begin
                    send_item(script[n].item, script[n].lit);
                end
            endcase
        end

        // Random phases, alternating the mode and walking through the idle mixes.
        for (int p = 0; p < PHASE_COUNT; p++) begin
            set_palette_mode(p % 2 == 0);
            send_idle_pct = SEND_IDLE[p / 2];
            recv_stall_pct <= RECV_STALL[p / 2];
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if ($urandom_range(59) == 0) begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    wait_for_results();
                end
                send_item(random_item(LOAD_PCT), NO_LITERAL);
            end
        end

        // Long receiver hold-off while pixels keep coming, so the input backs up.
        set_palette_mode(1'b0);
        send_idle_pct = 0;
        recv_stall_pct <= 0;
        hold_requests <= hold_requests + 1;
        for (int i = 0; i < PRESSURE_ITEMS; i++) begin
            send_item(random_item(0), NO_LITERAL);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_colors.size() != 0) begin
            $display("%0t: %0d color_index transfers never arrived", $time,
                     expected_colors.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
